@@ sv/assert_macros.svh @@
// Assertion macros shared by the formatter modules.
// Each expects clk and rst to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHK_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("formatter check failed");

// The consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("formatter check failed");

`endif

@@ sv/ita_pkg.sv @@
package ita_pkg;

  localparam int MAX_DIGITS = 22;
  localparam int DIG_W      = 4 * MAX_DIGITS;
  localparam int NDIG_W     = $clog2(MAX_DIGITS + 1);

  localparam logic [2:0] FN_SDEC = 3'd0;
  localparam logic [2:0] FN_UDEC = 3'd1;
  localparam logic [2:0] FN_OCT  = 3'd2;
  localparam logic [2:0] FN_HEX  = 3'd3;
  localparam logic [2:0] FN_PTR  = 3'd4;

  localparam logic [1:0] PAD_SPACE = 2'd0;
  localparam logic [1:0] PAD_ZERO  = 2'd1;
  localparam logic [1:0] PAD_DASH  = 2'd2;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_ALPHA = 8'h57;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic norm_step;
    logic pad_load;
    logic emit_prefix;
    logic emit_pad;
    logic emit_digit;
  } ita_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic norm_done;
    logic has_prefix;
    logic prefix_last;
    logic pads_zero;
    logic pads_one;
    logic digit_last;
    logic out_free;
  } ita_sts_t;

  function automatic logic [7:0] digit_char(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = CH_ZERO + {4'b0, nib};
    end else begin
      r = CH_ALPHA + {4'b0, nib};
    end
    return r;
  endfunction

endpackage

@@ sv/ita_dpath.sv @@
`include "assert_macros.svh"

module ita_dpath
  import ita_pkg::*;
#(
  parameter int MAX_WIDTH = 62
) (
  input  logic        clk,
  input  logic        rst,
  input  ita_cmd_t    cmd,
  output ita_sts_t    sts,
  input  logic [2:0]  func,
  input  logic [63:0] value,
  input  logic        long_long,
  input  logic [5:0]  min_width,
  input  logic [1:0]  pad_kind,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        last
);

  logic [63:0]       bin;
  logic [DIG_W-1:0]  dig;
  logic [NDIG_W-1:0] ndig;
  logic [4:0]        cnt;
  logic              is_dec;
  logic              neg;
  logic              ptr;
  logic              pfx_idx;
  logic [5:0]        pad_cnt;
  logic [5:0]        width_r;
  logic [7:0]        padc;

  logic [63:0]       v_signed;
  logic [63:0]       mag_ld;
  logic              neg_ld;
  logic              dec_ld;
  logic [DIG_W-1:0]  dig_ld;
  logic [DIG_W-1:0]  bcd_a;
  logic [DIG_W-1:0]  bcd_b;
  logic [63:0]       bin_a;
  logic [63:0]       bin_b;
  logic [DIG_W-1:0]  adj_a;
  logic [DIG_W-1:0]  adj_b;
  logic [7:0]        pfx_char;
  logic              emit;

  function automatic logic [DIG_W-1:0] add3(input logic [DIG_W-1:0] d);
    logic [DIG_W-1:0] r;
    logic [3:0]       nib;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      nib = d[4*i +: 4];
      r[4*i +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
    end
    return r;
  endfunction

  always_comb begin
    v_signed = long_long ? value : {{32{value[31]}}, value[31:0]};
    neg_ld   = (func == FN_SDEC) && v_signed[63];
    dec_ld   = !((func == FN_OCT) || (func == FN_HEX) || (func == FN_PTR));
    if (func == FN_PTR) begin
      mag_ld = value;
    end else if (func == FN_SDEC) begin
      mag_ld = neg_ld ? (64'd0 - v_signed) : v_signed;
    end else begin
      mag_ld = long_long ? value : {32'b0, value[31:0]};
    end
    dig_ld = '0;
    if (func == FN_OCT) begin
      for (int i = 0; i < MAX_DIGITS - 1; i++) begin
        dig_ld[4*i +: 4] = {1'b0, mag_ld[3*i +: 3]};
      end
      dig_ld[DIG_W-4 +: 4] = {3'b0, mag_ld[63]};
    end else if ((func == FN_HEX) || (func == FN_PTR)) begin
      dig_ld[63:0] = mag_ld;
    end
  end

  // Two shift-and-add-3 steps per cycle of the binary to BCD conversion.
  always_comb begin
    adj_a = add3(dig);
    bcd_a = {adj_a[DIG_W-2:0], bin[63]};
    bin_a = {bin[62:0], 1'b0};
    adj_b = add3(bcd_a);
    bcd_b = {adj_b[DIG_W-2:0], bin_a[63]};
    bin_b = {bin_a[62:0], 1'b0};
  end

  always_comb begin
    if (ptr) begin
      pfx_char = pfx_idx ? CH_X : CH_ZERO;
    end else begin
      pfx_char = CH_DASH;
    end
    emit = cmd.emit_prefix || cmd.emit_pad || cmd.emit_digit;
  end

  always_comb begin
    sts.conv_done   = !is_dec || (cnt == 5'd31);
    sts.norm_done   = (ndig == NDIG_W'(1)) || (dig[DIG_W-1 -: 4] != 4'd0);
    sts.has_prefix  = neg || ptr;
    sts.prefix_last = !ptr || pfx_idx;
    sts.pads_zero   = (pad_cnt == 6'd0);
    sts.pads_one    = (pad_cnt == 6'd1);
    sts.digit_last  = (ndig == NDIG_W'(1));
    sts.out_free    = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin     <= mag_ld;
      dig     <= dig_ld;
      ndig    <= NDIG_W'(MAX_DIGITS);
      cnt     <= 5'd0;
      is_dec  <= dec_ld;
      neg     <= neg_ld;
      ptr     <= (func == FN_PTR);
      pfx_idx <= 1'b0;
      width_r <= (min_width > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : min_width;
      unique case (pad_kind)
        PAD_ZERO: padc <= CH_ZERO;
        PAD_DASH: padc <= CH_DASH;
        default:  padc <= CH_SPACE;
      endcase
    end
    if (cmd.conv_step && is_dec) begin
      dig <= bcd_b;
      bin <= bin_b;
      cnt <= cnt + 5'd1;
    end
    if (cmd.norm_step || cmd.emit_digit) begin
      dig  <= {dig[DIG_W-5:0], 4'd0};
      ndig <= ndig - NDIG_W'(1);
    end
    if (cmd.pad_load) begin
      pad_cnt <= (width_r > 6'(ndig)) ? width_r - 6'(ndig) : 6'd0;
    end
    if (cmd.emit_pad) begin
      pad_cnt <= pad_cnt - 6'd1;
    end
    if (cmd.emit_prefix) begin
      pfx_idx <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      priority if (cmd.emit_digit) begin
        out_char <= digit_char(dig[DIG_W-1 -: 4]);
        last     <= sts.digit_last;
      end else if (cmd.emit_pad) begin
        out_char <= padc;
        last     <= 1'b0;
      end else begin
        out_char <= pfx_char;
        last     <= 1'b0;
      end
    end
  end

  `CHK_NEXT(a_digits_never_empty, cmd.emit_digit && !sts.digit_last, ndig != '0)
  `CHK_SAME(a_no_overwrite, emit, sts.out_free)

endmodule

@@ sv/ita_ctrl.sv @@
`include "assert_macros.svh"

module ita_ctrl
  import ita_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  ita_sts_t sts,
  output ita_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CONV   = 6'b000010,
    S_NORM   = 6'b000100,
    S_PREFIX = 6'b001000,
    S_PAD    = 6'b010000,
    S_DIGIT  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_stall   = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        cmd.conv_step = 1'b1;
        if (sts.conv_done) begin
          state_next = S_NORM;
        end
      end
      S_NORM: begin
        if (sts.norm_done) begin
          cmd.pad_load = 1'b1;
          state_next   = S_PREFIX;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      S_PREFIX: begin
        if (!sts.has_prefix) begin
          state_next = sts.pads_zero ? S_DIGIT : S_PAD;
        end else if (sts.out_free) begin
          cmd.emit_prefix = 1'b1;
          if (sts.prefix_last) begin
            state_next = sts.pads_zero ? S_DIGIT : S_PAD;
          end
        end
      end
      S_PAD: begin
        if (sts.out_free) begin
          cmd.emit_pad = 1'b1;
          if (sts.pads_one) begin
            state_next = S_DIGIT;
          end
        end
      end
      S_DIGIT: begin
        if (sts.out_free) begin
          cmd.emit_digit = 1'b1;
          if (sts.digit_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `CHK_NEXT(a_done_after_last, cmd.emit_digit && sts.digit_last, state == S_IDLE)
  `CHK_SAME(a_pad_nonempty, state == S_PAD, !sts.pads_zero)

endmodule

@@ sv/integer_to_ascii_formatter.sv @@
// Formats one integer per input word as a stream of ASCII characters, one
// character per output word, with last set on the final one. Signed decimal,
// unsigned decimal, octal, lower-case hex and pointer hex are supported (the
// spare func codes format as unsigned decimal); a negative signed value gets
// a leading minus and a pointer gets "0x", then pad characters until the
// digits fill min_width (capped at MAX_WIDTH), then the digits. An item is
// loaded, converted to BCD by shift-and-add-3 for decimal (octal and hex
// skip the conversion), stripped of leading zero digits down to at least
// one, has its pad count loaded and then emits its characters, one per
// cycle while the output is not stalled. The input is taken only while the
// controller is idle; the last character may still wait in the output
// register while the next word is accepted.
module integer_to_ascii_formatter
  import ita_pkg::*;
#(
  parameter int MAX_WIDTH = 62
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  func,
  input  logic [63:0] value,
  input  logic        long_long,
  input  logic [5:0]  min_width,
  input  logic [1:0]  pad_kind,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        last
);

  ita_cmd_t cmd;
  ita_sts_t sts;

  ita_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ita_dpath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .func      (func),
    .value     (value),
    .long_long (long_long),
    .min_width (min_width),
    .pad_kind  (pad_kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .last      (last)
  );

endmodule

@@ test/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ita_pkg::*;

  localparam int          WIDTH_CAP     = 62;
  localparam int          WATCHDOG_MAX  = 3000;
  localparam int          SETTLE_CYCLES = 120;
  localparam logic [2:0]  FN_SPARE_A    = 3'd5;
  localparam logic [2:0]  FN_SPARE_B    = 3'd6;
  localparam logic [2:0]  FN_SPARE_C    = 3'd7;
  localparam logic [1:0]  PAD_SPARE     = 2'd3;
  localparam logic [63:0] ALL_ONES      = 64'hffff_ffff_ffff_ffff;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  func = FN_SDEC;
  logic [63:0] value = '0;
  logic        long_long = 1'b0;
  logic [5:0]  min_width = '0;
  logic [1:0]  pad_kind = PAD_SPACE;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_char;
  logic        last;

  char_word_t  pending_chars[$];
  char_word_t  head_char;
  int          error_count = 0;
  int          quiet_cycles = 0;
  int          stall_left = 0;
  bit          stall_bursts = 1'b0;
  bit          feed_gaps = 1'b0;

  integer_to_ascii_formatter #(.MAX_WIDTH(WIDTH_CAP)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .value     (value),
    .long_long (long_long),
    .min_width (min_width),
    .pad_kind  (pad_kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .last      (last)
  );

  always #4 clk = ~clk;

  // Builds the character string that one request must produce and queues it.
  function automatic void predict_format(input logic [2:0] fn, input logic [63:0] raw,
                                         input logic wide, input logic [5:0] mw,
                                         input logic [1:0] pk);
    string       hex_digits;
    logic [63:0] num;
    logic [63:0] radix;
    logic [7:0]  fill;
    logic [7:0]  text[$];
    logic [7:0]  digits[$];
    int          field;
    int          fill_count;
    char_word_t  w;
    hex_digits = "0123456789abcdef";
    field = (mw > WIDTH_CAP) ? WIDTH_CAP : int'(mw);
    case (pk)
      PAD_ZERO: fill = CH_ZERO;
      PAD_DASH: fill = CH_DASH;
      default:  fill = CH_SPACE;
    endcase
    if (fn == FN_PTR) begin
      num = raw;
      radix = 64'd16;
      text.push_back(CH_ZERO);
      text.push_back(CH_X);
    end else if (fn == FN_SDEC) begin
      num = wide ? raw : {{32{raw[31]}}, raw[31:0]};
      radix = 64'd10;
      if (num[63]) begin
        text.push_back(CH_DASH);
        num = 64'd0 - num;
      end
    end else begin
      num = wide ? raw : {32'd0, raw[31:0]};
      radix = (fn == FN_OCT) ? 64'd8 : (fn == FN_HEX) ? 64'd16 : 64'd10;
    end
    do begin
      digits.push_front(hex_digits[int'(num % radix)]);
      num = num / radix;
    end while (num != 64'd0);
    fill_count = (field > digits.size()) ? field - digits.size() : 0;
    repeat (fill_count) text.push_back(fill);
    foreach (digits[i]) text.push_back(digits[i]);
    foreach (text[i]) begin
      w.ch = text[i];
      w.last = (i == text.size() - 1);
      pending_chars.push_back(w);
    end
  endfunction

  task automatic format_request(input logic [2:0] fn, input logic [63:0] raw,
                                input logic wide, input logic [5:0] mw,
                                input logic [1:0] pk);
    int gap;
    if (feed_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    func      <= fn;
    value     <= raw;
    long_long <= wide;
    min_width <= mw;
    pad_kind  <= pk;
    do @(posedge clk); while (!(in_valid && !in_stall));
    predict_format(fn, raw, wide, mw, pk);
  endtask

  // Holds the input side until every queued character has been checked.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    case ($urandom_range(0, 6))
      0: v = 64'($urandom_range(0, 20));
      1: v = {$urandom, $urandom};
      2: v = {$urandom, 32'h8000_0000 | 32'($urandom_range(0, 255))};
      3: v = 64'd1 << $urandom_range(0, 63);
      4: v = ALL_ONES >> $urandom_range(0, 63);
      5: v = {32'($urandom), 32'($urandom_range(0, 99999))};
      default: v = ALL_ONES - 64'($urandom_range(0, 3));
    endcase
    return v;
  endfunction

  task automatic send_random_request();
    logic [2:0] fn;
    logic [5:0] mw;
    fn = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    mw = ($urandom_range(0, 5) == 0) ? 6'($urandom_range(25, 63)) : 6'($urandom_range(0, 24));
    format_request(fn, pick_value(), 1'($urandom), mw, 2'($urandom));
  endtask

  task automatic test_directed();
    stall_bursts = 1'b1;
    feed_gaps = 1'b1;
    format_request(FN_SDEC, 64'd0, 1'b0, 6'd0, PAD_SPACE);
    format_request(FN_SDEC, 64'd0, 1'b0, 6'd5, PAD_ZERO);
    format_request(FN_SDEC, 64'h1234_5678_ffff_ffff, 1'b0, 6'd0, PAD_SPACE);
    format_request(FN_SDEC, 64'h0000_0000_8000_0000, 1'b0, 6'd12, PAD_DASH);
    format_request(FN_SDEC, 64'h8000_0000_0000_0000, 1'b1, 6'd0, PAD_SPACE);
    format_request(FN_SDEC, 64'h7fff_ffff_ffff_ffff, 1'b1, 6'd62, PAD_ZERO);
    format_request(FN_SDEC, 64'hffff_ffff_7fff_ffff, 1'b0, 6'd1, PAD_SPACE);
    format_request(FN_SDEC, 64'd5, 1'b0, 6'd3, PAD_SPARE);
    format_request(FN_UDEC, ALL_ONES, 1'b1, 6'd0, PAD_SPACE);
    format_request(FN_UDEC, ALL_ONES, 1'b0, 6'd63, PAD_SPARE);
    format_request(FN_OCT, ALL_ONES, 1'b1, 6'd63, PAD_ZERO);
    format_request(FN_OCT, 64'd0, 1'b0, 6'd1, PAD_DASH);
    format_request(FN_HEX, 64'hfedc_ba98_7654_3210, 1'b1, 6'd0, PAD_SPACE);
    format_request(FN_HEX, 64'hfedc_ba98_7654_3210, 1'b0, 6'd10, PAD_DASH);
    format_request(FN_HEX, 64'd10, 1'b0, 6'd2, PAD_ZERO);
    format_request(FN_PTR, 64'd0, 1'b0, 6'd0, PAD_SPACE);
    format_request(FN_PTR, ALL_ONES, 1'b0, 6'd62, PAD_SPACE);
    format_request(FN_SPARE_A, ALL_ONES, 1'b0, 6'd0, PAD_SPACE);
    format_request(FN_SPARE_B, 64'd12345, 1'b1, 6'd8, PAD_ZERO);
    format_request(FN_SPARE_C, 64'h8000_0000_0000_0000, 1'b1, 6'd25, PAD_SPARE);
  endtask

  task automatic test_random_mix();
    for (int n = 0; n < 130; n++) begin
      if (n % 20 == 0) begin
        stall_bursts = ($urandom_range(0, 3) != 0);
        feed_gaps = ($urandom_range(0, 3) != 0);
      end
      if (n == 65) begin
        hold_until_drained();
      end
      send_random_request();
    end
  endtask

  // Final stretch: both sides run flat out.
  task automatic test_back_to_back();
    stall_bursts = 1'b0;
    feed_gaps = 1'b0;
    repeat (30) send_random_request();
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (stall_bursts && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 18);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected word: out_char %h last %b", out_char, last);
        error_count++;
      end else begin
        head_char = pending_chars.pop_front();
        if (out_char !== head_char.ch) begin
          $error("out_char expected %h actual %h", head_char.ch, out_char);
          error_count++;
        end
        if (last !== head_char.last) begin
          $error("last expected %b actual %b", head_char.last, last);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_mix();
    test_back_to_back();
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_chars.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
